[design/frd_pkg.sv]
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the flood relay duplicate filter
// Verdict codes, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package frd_pkg;

  // field widths
  localparam int unsigned NodeW  = 16;
  localparam int unsigned SerW   = 16;
  localparam int unsigned HopW   = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned KeyW   = NodeW + SerW;
  localparam int unsigned CfgW   = 16;

  // register indexes on the configuration port
  localparam logic CfgOwnNodeId = 1'b0;
  localparam logic CfgHopLimit  = 1'b1;

  // reset values of the registers
  localparam logic [NodeW-1:0] OwnNodeIdReset = 16'd0;
  localparam logic [HopW-1:0]  HopLimitReset  = 8'd10;

  // relay decision codes
  typedef enum logic [2:0] {
    VERDICT_FORWARD = 3'd0,
    VERDICT_BADLEN  = 3'd1,
    VERDICT_HOPS    = 3'd2,
    VERDICT_DUP     = 3'd3,
    VERDICT_OWN     = 3'd4
  } verdict_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_INSERT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic     load;       // capture the input item
    logic     scan_clr;   // restart the cache scan
    logic     scan_step;  // issue the next cache read
    logic     insert;     // store the pair in the cache
    logic     emit;       // load the result registers
    verdict_e verdict;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_bad;
    logic hops_bad;
    logic hit;
    logic scan_end;
    logic own;
  } ctrl_sts_t;

endpackage

[design/frd_ctrl.sv]
// ----------------------------------------------------------------------------
// frd_ctrl: relay decision sequencer
// Walks each item through the length and hop checks, the cache scan and the
// cache insert, and tells the datapath which verdict to post.
// ----------------------------------------------------------------------------
module frd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  frd_pkg::ctrl_sts_t sts_i,
  output frd_pkg::ctrl_cmd_t cmd_o
);

  frd_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != frd_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.verdict = frd_pkg::VERDICT_FORWARD;
    unique case (state_q)
      frd_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = frd_pkg::ST_CHECK;
        end
      end
      frd_pkg::ST_CHECK: begin
        if (sts_i.len_bad) begin
          cmd_o.emit    = 1'b1;
          cmd_o.verdict = frd_pkg::VERDICT_BADLEN;
          state_d       = frd_pkg::ST_IDLE;
        end else if (sts_i.hops_bad) begin
          cmd_o.emit    = 1'b1;
          cmd_o.verdict = frd_pkg::VERDICT_HOPS;
          state_d       = frd_pkg::ST_IDLE;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = frd_pkg::ST_SCAN;
        end
      end
      frd_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.emit    = 1'b1;
          cmd_o.verdict = frd_pkg::VERDICT_DUP;
          state_d       = frd_pkg::ST_IDLE;
        end else if (sts_i.scan_end) begin
          state_d = frd_pkg::ST_INSERT;
        end
      end
      frd_pkg::ST_INSERT: begin
        cmd_o.insert  = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.verdict = sts_i.own ? frd_pkg::VERDICT_OWN : frd_pkg::VERDICT_FORWARD;
        state_d       = frd_pkg::ST_IDLE;
      end
      default: begin
        state_d = frd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/frd_datapath.sv]
// ----------------------------------------------------------------------------
// frd_datapath: item registers, settings, pair cache and result registers
// The cache is a ring memory of origin and serial pairs with a fill count;
// the scan reads one entry per cycle and compares the registered data.
// ----------------------------------------------------------------------------
module frd_datapath #(
  parameter int unsigned CACHE_DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  frd_pkg::ctrl_cmd_t               cmd_i,
  output frd_pkg::ctrl_sts_t               sts_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [frd_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                             length_ok_i,
  input  logic [frd_pkg::NodeW-1:0]        msg_origin_i,
  input  logic [frd_pkg::SerW-1:0]         msg_serial_i,
  input  logic [frd_pkg::HopW-1:0]         hop_count_i,
  input  logic [frd_pkg::StampW-1:0]       timestamp_i,
  output logic                             done_o,
  output logic                             forward_o,
  output logic [2:0]                       verdict_o,
  output logic [frd_pkg::NodeW-1:0]        out_origin_o,
  output logic [frd_pkg::SerW-1:0]         out_serial_o,
  output logic [frd_pkg::HopW-1:0]         out_hops_o,
  output logic [frd_pkg::StampW-1:0]       out_timestamp_o
);

  localparam int unsigned AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC   = CW'(CACHE_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(CACHE_DEPTH - 1);

  // settings
  logic [frd_pkg::NodeW-1:0] own_id_q;
  logic [frd_pkg::HopW-1:0]  hop_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= frd_pkg::OwnNodeIdReset;
      hop_limit_q <= frd_pkg::HopLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frd_pkg::CfgOwnNodeId: own_id_q    <= cfg_wdata_i[frd_pkg::NodeW-1:0];
        frd_pkg::CfgHopLimit:  hop_limit_q <= cfg_wdata_i[frd_pkg::HopW-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic                       len_ok_q;
  logic [frd_pkg::NodeW-1:0]  origin_q;
  logic [frd_pkg::SerW-1:0]   serial_q;
  logic [frd_pkg::HopW-1:0]   hops_q;
  logic [frd_pkg::StampW-1:0] stamp_q;
  logic [frd_pkg::KeyW-1:0]   key;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_ok_q <= length_ok_i;
      origin_q <= msg_origin_i;
      serial_q <= msg_serial_i;
      hops_q   <= hop_count_i;
      stamp_q  <= timestamp_i;
    end
  end

  assign key = {origin_q, serial_q};

  // cache bookkeeping
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          full;
  logic          rd_en;
  logic [AW-1:0] wr_addr;

  assign full    = (fill_q >= DepthC);
  assign rd_en   = cmd_i.scan_step && (idx_q < fill_q);
  assign wr_addr = full ? oldest_q : fill_q[AW-1:0];

  always_comb begin
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.scan_clr) begin
      idx_d     = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + CW'(1);
      end
    end
    if (cmd_i.insert) begin
      if (!full) begin
        fill_d = fill_q + CW'(1);
      end else if (oldest_q == LastSlot) begin
        oldest_d = '0;
      end else begin
        oldest_d = oldest_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      oldest_q  <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // pair memory, one write and one registered read port
  logic [frd_pkg::KeyW-1:0] mem_q [CACHE_DEPTH];
  logic [frd_pkg::KeyW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      mem_q[wr_addr] <= key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  // status back to the controller
  assign sts_o.len_bad  = !len_ok_q;
  assign sts_o.hops_bad = (hops_q >= hop_limit_q);
  assign sts_o.hit      = cmp_vld_q && (rd_data_q == key);
  assign sts_o.scan_end = !cmp_vld_q && (idx_q >= fill_q);
  assign sts_o.own      = (origin_q == own_id_q);

  // result registers
  logic                       done_q;
  logic                       fwd_q;
  frd_pkg::verdict_e          verdict_q;
  logic [frd_pkg::NodeW-1:0]  res_origin_q;
  logic [frd_pkg::SerW-1:0]   res_serial_q;
  logic [frd_pkg::HopW-1:0]   res_hops_q;
  logic [frd_pkg::StampW-1:0] res_stamp_q;
  logic                       fwd;

  assign fwd = (cmd_i.verdict == frd_pkg::VERDICT_FORWARD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fwd_q        <= fwd;
      verdict_q    <= cmd_i.verdict;
      res_origin_q <= fwd ? origin_q : '0;
      res_serial_q <= fwd ? serial_q : '0;
      res_hops_q   <= fwd ? (hops_q + frd_pkg::HopW'(1)) : '0;
      res_stamp_q  <= fwd ? stamp_q : '0;
    end
  end

  assign done_o          = done_q;
  assign forward_o       = fwd_q;
  assign verdict_o       = verdict_q;
  assign out_origin_o    = res_origin_q;
  assign out_serial_o    = res_serial_q;
  assign out_hops_o      = res_hops_q;
  assign out_timestamp_o = res_stamp_q;

endmodule

[design/flood_relay_duplicate_filter.sv]
// ----------------------------------------------------------------------------
// flood_relay_duplicate_filter: relay decision for a flooding mesh
// Drops bad-length, hop-limited, duplicate and own-origin messages and
// forwards the rest with the hop count incremented.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start, busy            length_ok_i, msg_origin_i, msg_serial_i,
//                                   hop_count_i, timestamp_i
//  result    done_o (strobe)        forward_o, verdict_o, out_origin_o,
//                                   out_serial_o, out_hops_o, out_timestamp_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// An item is taken when start is high and busy is low; busy drops in the
// cycle done_o strobes. A length or hop drop is decided in the check state.
// The scan reads one cache entry per cycle and compares it in the cycle
// after, from the registered read data; a new pair is stored and strobes
// once the scan ends, and a duplicate ends the scan early.
// Reset empties the cache and loads the register defaults; no result stalls.
// ----------------------------------------------------------------------------
module flood_relay_duplicate_filter #(
  parameter int unsigned CACHE_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [frd_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       length_ok_i,
  input  logic [frd_pkg::NodeW-1:0]  msg_origin_i,
  input  logic [frd_pkg::SerW-1:0]   msg_serial_i,
  input  logic [frd_pkg::HopW-1:0]   hop_count_i,
  input  logic [frd_pkg::StampW-1:0] timestamp_i,
  output logic                       done_o,
  output logic                       forward_o,
  output logic [2:0]                 verdict_o,
  output logic [frd_pkg::NodeW-1:0]  out_origin_o,
  output logic [frd_pkg::SerW-1:0]   out_serial_o,
  output logic [frd_pkg::HopW-1:0]   out_hops_o,
  output logic [frd_pkg::StampW-1:0] out_timestamp_o
);

  frd_pkg::ctrl_cmd_t cmd;
  frd_pkg::ctrl_sts_t sts;

  // sequencer
  frd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath and pair cache
  frd_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .length_ok_i     (length_ok_i),
    .msg_origin_i    (msg_origin_i),
    .msg_serial_i    (msg_serial_i),
    .hop_count_i     (hop_count_i),
    .timestamp_i     (timestamp_i),
    .done_o          (done_o),
    .forward_o       (forward_o),
    .verdict_o       (verdict_o),
    .out_origin_o    (out_origin_o),
    .out_serial_o    (out_serial_o),
    .out_hops_o      (out_hops_o),
    .out_timestamp_o (out_timestamp_o)
  );

endmodule
